// File: hdl/ptdc_pkg.sv
// Shared types and constants for the PID temperature duty controller.
// No dependencies; imported by the top level, its port checker, the scoreboard and the testbench.
package ptdc_pkg;

    // Converter resolution and the widths that follow from the field list
    localparam int ADC_BITS   = 10;
    localparam int ADC_PORT_W = 10;
    localparam int MEAS_W     = 20;   // holds the largest code times ten
    localparam int SP_W       = 14;
    localparam int DUTY_W     = 7;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 16;
    localparam int INT_W      = 32;
    localparam int KEY_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 16;

    localparam logic [3:0]        ADC_SCALE     = 4'd10;
    localparam logic [SP_W-1:0]   SP_MAX        = 14'd10000;
    localparam logic [SP_W-1:0]   SP_RESET      = 14'd3000;
    localparam logic [SP_W-1:0]   SP_STEP_SMALL = 14'd100;
    localparam logic [SP_W-1:0]   SP_STEP_LARGE = 14'd1000;
    localparam logic [DUTY_W-1:0] DUTY_RESET    = 7'd100;

    localparam logic [GAIN_W-1:0] KP_RESET = 16'd655;
    localparam logic [GAIN_W-1:0] KI_RESET = 16'd66;
    localparam logic [GAIN_W-1:0] KD_RESET = 16'd3277;

    typedef logic [KEY_W-1:0] t_key_code;

    localparam t_key_code KEY_UP_SMALL = 8'h14;
    localparam t_key_code KEY_DN_SMALL = 8'h24;
    localparam t_key_code KEY_UP_LARGE = 8'h44;
    localparam t_key_code KEY_DN_LARGE = 8'h84;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 2'd0,
        CFG_KI       = 2'd1,
        CFG_KD       = 2'd2,
        CFG_DUTY_MAX = 2'd3
    } t_cfg_idx;

endpackage

// File: hdl/pid_temperature_duty_controller_top.sv
// An accepted word waits in the input register and then moves into the result
// register; one word per cycle while the result side is not stalled.
// The PID update, the three gain multiplies and the clamp sit in one stage
// between the input register and the result/state registers.
// Reset (i_rst_n low, synchronous) empties both stages, restores the gains,
// setpoint 3000, integral and last error 0, and duty 100.
// Depends on ptdc_pkg.
module pid_temperature_duty_controller_top
    import ptdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [ADC_PORT_W-1:0] i_adc_sample,
    input  logic [KEY_W-1:0]      i_key_code,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DUTY_W-1:0]     o_duty,
    output logic [SP_W-1:0]       o_setpoint_now,
    output logic [SP_W-1:0]       o_measured_temp
);

    localparam int TOT_W = GAIN_W + INT_W + 3;
    localparam int Q_W   = TOT_W - FRAC_BITS;

    localparam logic signed [MEAS_W:0] ERR_HI = (MEAS_W+1)'(32'sd32767);
    localparam logic signed [MEAS_W:0] ERR_LO = (MEAS_W+1)'(-32'sd32768);

    // configuration registers
    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [GAIN_W-1:0] r_kd;
    logic [DUTY_W-1:0] r_duty_max;

    // input register stage
    logic                  r_a_valid;
    logic                  r_a_mode;
    logic [ADC_PORT_W-1:0] r_a_adc;
    t_key_code             r_a_key;

    // controller state; duty and setpoint double as the result fields
    logic [SP_W-1:0]          r_setpoint;
    logic signed [INT_W-1:0]  r_integral;
    logic signed [ERR_W-1:0]  r_last_error;
    logic [DUTY_W-1:0]        r_last_duty;

    // result register stage
    logic            r_b_valid;
    logic [SP_W-1:0] r_meas;

    logic b_adv;
    logic a_fire;

    // next-state values from the compute stage
    logic [MEAS_W-1:0]        n_meas;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [INT_W-1:0]  n_integral;
    logic [DUTY_W-1:0]        n_duty;
    logic [SP_W-1:0]          n_setpoint;

    // ------------------------------------------------------------------
    // Handshake: the result register advances when empty or taken; the
    // input register takes a word when empty or when it hands its word on.
    // ------------------------------------------------------------------
    assign b_adv   = !r_b_valid || i_ready;
    assign a_fire  = r_a_valid && b_adv;
    assign o_ready = !r_a_valid || b_adv;
    assign o_valid = r_b_valid;

    // State only changes when a word moves into the result register, so
    // these hold steady while the result is stalled.
    assign o_duty          = r_last_duty;
    assign o_setpoint_now  = r_setpoint;
    assign o_measured_temp = r_meas;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= KP_RESET;
            r_ki       <= KI_RESET;
            r_kd       <= KD_RESET;
            r_duty_max <= DUTY_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP:       r_kp       <= i_cfg_data;
                CFG_KI:       r_ki       <= i_cfg_data;
                CFG_KD:       r_kd       <= i_cfg_data;
                CFG_DUTY_MAX: r_duty_max <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // PID sample path: error, saturating integral, difference, the three
    // products and the clamp to 0..duty_max.
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [MEAS_W:0]          err_wide;
        logic signed [INT_W:0]           sum_wide;
        logic signed [ERR_W:0]           diff;
        logic signed [GAIN_W+ERR_W:0]    p_kp;
        logic signed [GAIN_W+INT_W:0]    p_ki;
        logic signed [GAIN_W+ERR_W+1:0]  p_kd;
        logic signed [TOT_W-1:0]         total;
        logic [Q_W-1:0]                  q;

        n_meas   = MEAS_W'(r_a_adc[ADC_BITS-1:0]) * MEAS_W'(ADC_SCALE);
        err_wide = $signed({1'b0, MEAS_W'(r_setpoint)}) - $signed({1'b0, n_meas});

        // saturate the error to its 16-bit register
        if (err_wide > ERR_HI) begin
            n_err = ERR_W'(ERR_HI);
        end else if (err_wide < ERR_LO) begin
            n_err = ERR_W'(ERR_LO);
        end else begin
            n_err = err_wide[ERR_W-1:0];
        end

        // integral saturates at the 32-bit signed limits
        sum_wide = (INT_W+1)'(r_integral) + (INT_W+1)'(n_err);
        if (sum_wide[INT_W] != sum_wide[INT_W-1]) begin
            n_integral = sum_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                         : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            n_integral = sum_wide[INT_W-1:0];
        end

        diff = (ERR_W+1)'(n_err) - (ERR_W+1)'(r_last_error);

        p_kp = $signed({1'b0, r_kp}) * n_err;
        p_ki = $signed({1'b0, r_ki}) * n_integral;
        p_kd = $signed({1'b0, r_kd}) * diff;

        total = TOT_W'(p_kp) + TOT_W'(p_ki) + TOT_W'(p_kd);
        q     = total[TOT_W-1:FRAC_BITS];

        // negative drive gives zero duty; otherwise truncate and clamp
        if (total[TOT_W-1]) begin
            n_duty = '0;
        end else if (q > Q_W'(r_duty_max)) begin
            n_duty = r_duty_max;
        end else begin
            n_duty = q[DUTY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Key path: step the setpoint, saturating at 0 and the upper limit.
    // ------------------------------------------------------------------
    always_comb begin
        logic [SP_W:0] up_small;
        logic [SP_W:0] up_large;

        up_small = (SP_W+1)'(r_setpoint) + (SP_W+1)'(SP_STEP_SMALL);
        up_large = (SP_W+1)'(r_setpoint) + (SP_W+1)'(SP_STEP_LARGE);

        case (r_a_key)
            KEY_UP_SMALL: begin
                n_setpoint = (up_small >= (SP_W+1)'(SP_MAX)) ? SP_MAX
                                                             : up_small[SP_W-1:0];
            end
            KEY_DN_SMALL: begin
                n_setpoint = (r_setpoint <= SP_STEP_SMALL) ? '0
                                                           : r_setpoint - SP_STEP_SMALL;
            end
            KEY_UP_LARGE: begin
                n_setpoint = (up_large >= (SP_W+1)'(SP_MAX)) ? SP_MAX
                                                             : up_large[SP_W-1:0];
            end
            KEY_DN_LARGE: begin
                n_setpoint = (r_setpoint <= SP_STEP_LARGE) ? '0
                                                           : r_setpoint - SP_STEP_LARGE;
            end
            default: n_setpoint = r_setpoint;   // unknown code: no step
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_mode <= i_mode;
            r_a_adc  <= i_adc_sample;
            r_a_key  <= i_key_code;
        end
    end

    // ------------------------------------------------------------------
    // Result register and controller state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_setpoint   <= SP_RESET;
            r_integral   <= '0;
            r_last_error <= '0;
            r_last_duty  <= DUTY_RESET;
        end else begin
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
            if (a_fire) begin
                if (!r_a_mode) begin
                    r_integral   <= n_integral;
                    r_last_error <= n_err;
                    r_last_duty  <= n_duty;
                end else begin
                    // key event: step setpoint, clear the PID history, hold duty
                    r_setpoint   <= n_setpoint;
                    r_integral   <= '0;
                    r_last_error <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_meas <= r_a_mode ? '0 : n_meas[SP_W-1:0];
        end
    end

endmodule

// File: hdl/ptdc_checker.sv
// Port-level checker for the PID temperature duty controller, with its bind.
// Depends on ptdc_pkg and pid_temperature_duty_controller_top.
module ptdc_checker
    import ptdc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_ready,
    input logic              o_ready,
    input logic              o_valid,
    input logic [DUTY_W-1:0] o_duty,
    input logic [SP_W-1:0]   o_setpoint_now,
    input logic [SP_W-1:0]   o_measured_temp
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled word holds its fields.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_duty)
            && $stable(o_setpoint_now) && $stable(o_measured_temp))
        else $error("stalled result changed");

    // Input side only backs up when the result side is stalled.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output backpressure");

    // Setpoint stays in its range.
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_setpoint_now <= SP_MAX)
        else $error("setpoint out of range");

endmodule

bind pid_temperature_duty_controller_top ptdc_checker u_ptdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_ready         (i_ready),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .o_duty          (o_duty),
    .o_setpoint_now  (o_setpoint_now),
    .o_measured_temp (o_measured_temp)
);

// File: dv/ptdc_duty_sb_pkg.sv
// Scoreboard for the PID temperature duty controller: a cycle-free predictor
// of the duty, setpoint and temperature words plus the queue of words due.
// Depends on ptdc_pkg for widths, reset values, key codes and register indexes.
package ptdc_duty_sb_pkg;
    import ptdc_pkg::*;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [SP_W-1:0]   setpoint_now;
        logic [SP_W-1:0]   measured_temp;
    } t_duty_word;

    localparam longint ERR_HI = (longint'(1) <<< (ERR_W - 1)) - 1;
    localparam longint ERR_LO = -(longint'(1) <<< (ERR_W - 1));
    localparam longint INT_HI = (longint'(1) <<< (INT_W - 1)) - 1;
    localparam longint INT_LO = -(longint'(1) <<< (INT_W - 1));

    class pid_duty_scoreboard;
        logic [GAIN_W-1:0]       kp;
        logic [GAIN_W-1:0]       ki;
        logic [GAIN_W-1:0]       kd;
        logic [DUTY_W-1:0]       duty_cap;
        logic [SP_W-1:0]         setpoint;
        logic signed [INT_W-1:0] integ;
        logic signed [ERR_W-1:0] prev_err;
        logic [DUTY_W-1:0]       held_duty;
        t_duty_word              duty_words_due[$];
        int unsigned             mismatches;

        function new();
            kp         = KP_RESET;
            ki         = KI_RESET;
            kd         = KD_RESET;
            duty_cap   = DUTY_RESET;
            setpoint   = SP_RESET;
            integ      = '0;
            prev_err   = '0;
            held_duty  = DUTY_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KP:       kp = data;
                CFG_KI:       ki = data;
                CFG_KD:       kd = data;
                CFG_DUTY_MAX: duty_cap = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        // Step the setpoint, pinned to 0 and SP_MAX; unknown codes leave it.
        function logic [SP_W-1:0] stepped_setpoint(t_key_code key);
            longint sp;
            longint step;
            sp = setpoint;
            case (key)
                KEY_UP_SMALL, KEY_UP_LARGE: begin
                    step = (key == KEY_UP_SMALL) ? SP_STEP_SMALL : SP_STEP_LARGE;
                    sp = sp + step;
                    if (sp > SP_MAX) sp = SP_MAX;
                end
                KEY_DN_SMALL, KEY_DN_LARGE: begin
                    step = (key == KEY_DN_SMALL) ? SP_STEP_SMALL : SP_STEP_LARGE;
                    sp = (sp <= step) ? 0 : sp - step;
                end
                default: ;
            endcase
            return sp[SP_W-1:0];
        endfunction

        function t_duty_word next_duty_word(logic mode, logic [ADC_PORT_W-1:0] adc,
                                            t_key_code key);
            longint     meas;
            longint     err;
            longint     sum;
            longint     diff;
            longint     total;
            t_duty_word w;
            meas = 0;
            if (mode == 1'b0) begin
                meas = longint'(adc) * ADC_SCALE;
                err  = longint'(setpoint) - meas;
                if (err > ERR_HI) err = ERR_HI;
                if (err < ERR_LO) err = ERR_LO;
                sum = longint'(integ) + err;
                if (sum > INT_HI) sum = INT_HI;
                if (sum < INT_LO) sum = INT_LO;
                diff     = err - longint'(prev_err);
                integ    = sum[INT_W-1:0];
                prev_err = err[ERR_W-1:0];
                total = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * diff;
                if (total < 0)
                    held_duty = '0;
                else if ((total >>> FRAC_BITS) > longint'(duty_cap))
                    held_duty = duty_cap;
                else
                    held_duty = total[FRAC_BITS+DUTY_W-1:FRAC_BITS];
            end else begin
                setpoint = stepped_setpoint(key);
                integ    = '0;
                prev_err = '0;
            end
            w.duty          = held_duty;
            w.setpoint_now  = setpoint;
            w.measured_temp = meas[SP_W-1:0];
            return w;
        endfunction

        function void note_word(logic mode, logic [ADC_PORT_W-1:0] adc, t_key_code key);
            duty_words_due.push_back(next_duty_word(mode, adc, key));
        endfunction

        function void check_result(logic [DUTY_W-1:0] duty, logic [SP_W-1:0] sp,
                                   logic [SP_W-1:0] meas);
            t_duty_word want;
            if (duty_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: duty %0d setpoint %0d temp %0d",
                             duty, sp, meas);
                return;
            end
            want = duty_words_due.pop_front();
            if (want.duty !== duty || want.setpoint_now !== sp || want.measured_temp !== meas)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: duty %0d/%0d setpoint %0d/%0d temp %0d/%0d (exp/act)",
                             want.duty, duty, want.setpoint_now, sp,
                             want.measured_temp, meas);
            end
        endfunction

        function int pending();
            return duty_words_due.size();
        endfunction
    endclass

endpackage

// File: dv/tb.sv
// Testbench top for the PID temperature duty controller: drives sample and key
// words with random gaps, checks every result word against the scoreboard.
// Depends on ptdc_pkg and ptdc_duty_sb_pkg.
module tb;
    import ptdc_pkg::*;
    import ptdc_duty_sb_pkg::*;

    localparam int STALL_LIMIT        = 5000;   // quiet cycles before giving up
    localparam int DRAIN_LIMIT        = 2000;
    localparam int RANDOM_PHASES      = 8;
    localparam int RANDOM_PHASE_WORDS = 110;
    localparam int HOLD_CYCLES        = 300;
    localparam int MAX_GAP            = 30;
    // Back-to-back samples held at one end of the scale to wind up the integral
    localparam int POS_SAT_WORDS      = 40;
    localparam int NEG_SAT_WORDS      = 40;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic                  i_mode       = 1'b0;
    logic [ADC_PORT_W-1:0] i_adc_sample = '0;
    logic [KEY_W-1:0]      i_key_code   = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [DUTY_W-1:0]     o_duty;
    logic [SP_W-1:0]       o_setpoint_now;
    logic [SP_W-1:0]       o_measured_temp;

    pid_duty_scoreboard sb;
    bit                 idle_on   = 1'b1;   // random gaps on both sides
    int unsigned        hold_left = 0;      // receiver hold-off still to run

    pid_temperature_duty_controller_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_adc_sample    (i_adc_sample),
        .i_key_code      (i_key_code),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_duty          (o_duty),
        .o_setpoint_now  (o_setpoint_now),
        .o_measured_temp (o_measured_temp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: check the word taken at this edge, then pick next ready.
    // A pending hold-off wins over the random idling.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_valid && i_ready)
                    sb.check_result(o_duty, o_setpoint_now, o_measured_temp);
                if (hold_left != 0) begin
                    i_ready <= 1'b0;
                    hold_left--;
                end else if (idle_on) begin
                    i_ready <= ($urandom_range(99) >= 20);
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[pid_temperature_duty_controller_top] ERROR");
        $finish;
    end

    // Offer one word and hold it until accepted. Valid is left high afterwards
    // so a following word goes out back to back; a gap drops it first.
    task automatic send_word(input logic mode, input logic [ADC_PORT_W-1:0] adc,
                             input t_key_code key);
        int gap;
        gap = 0;
        if (idle_on)
            while (gap < MAX_GAP && $urandom_range(99) < 20) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_adc_sample <= adc;
        i_key_code   <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(mode, adc, key);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges, enable held high throughout
    task automatic apply_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd, input logic [DUTY_W-1:0] cap);
        logic [CFG_DATA_W-1:0] cap_data;
        cap_data = {{(CFG_DATA_W-DUTY_W){1'b0}}, cap};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KP;
        i_cfg_data <= kp;
        @(posedge i_clk);
        sb.set_reg(CFG_KP, kp);
        i_cfg_idx  <= CFG_KI;
        i_cfg_data <= ki;
        @(posedge i_clk);
        sb.set_reg(CFG_KI, ki);
        i_cfg_idx  <= CFG_KD;
        i_cfg_data <= kd;
        @(posedge i_clk);
        sb.set_reg(CFG_KD, kd);
        i_cfg_idx  <= CFG_DUTY_MAX;
        i_cfg_data <= cap_data;
        @(posedge i_clk);
        sb.set_reg(CFG_DUTY_MAX, cap_data);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly samples, half of them near the setpoint so the duty lands
    // inside the clamp; the rest are known keys and arbitrary key bytes.
    task automatic send_random_word();
        int pick;
        int code;
        pick = $urandom_range(99);
        if (pick < 78) begin
            if ($urandom_range(1) == 0) begin
                code = int'(sb.setpoint) / 10 + int'($urandom_range(40)) - 20;
                if (code < 0) code = 0;
                if (code > 1023) code = 1023;
            end else begin
                code = $urandom_range(1023);
            end
            send_word(1'b0, code[ADC_PORT_W-1:0], KEY_W'($urandom_range(255)));
        end else if (pick < 93) begin
            case ($urandom_range(3))
                0: send_word(1'b1, ADC_PORT_W'($urandom_range(1023)), KEY_UP_SMALL);
                1: send_word(1'b1, ADC_PORT_W'($urandom_range(1023)), KEY_DN_SMALL);
                2: send_word(1'b1, ADC_PORT_W'($urandom_range(1023)), KEY_UP_LARGE);
                default: send_word(1'b1, ADC_PORT_W'($urandom_range(1023)), KEY_DN_LARGE);
            endcase
        end else begin
            send_word(1'b1, ADC_PORT_W'($urandom_range(1023)),
                      KEY_W'($urandom_range(255)));
        end
    endtask

    initial begin
        int unsigned waited;
        logic [ADC_PORT_W-1:0] adc;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: coldest, hottest and on-target readings
        send_word(1'b0, 10'd0, 8'h00);
        send_word(1'b0, 10'd1023, 8'hFF);
        send_word(1'b0, 10'd300, 8'h00);
        // Both small keys, then unknown codes that only clear the PID state
        send_word(1'b1, 10'd0, KEY_UP_SMALL);
        send_word(1'b1, 10'd0, KEY_DN_SMALL);
        send_word(1'b1, 10'd0, 8'h00);
        send_word(1'b1, 10'h3FF, 8'hFF);
        // Climb to the top setpoint, then push past it
        repeat (7) send_word(1'b1, 10'd0, KEY_UP_LARGE);
        send_word(1'b1, 10'd0, KEY_UP_SMALL);
        send_word(1'b0, 10'd0, 8'h00);
        send_word(1'b0, 10'd1023, 8'h00);

        // Largest gains and the widest clamp
        drain_results();
        apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
        send_word(1'b0, 10'd0, 8'h00);
        send_word(1'b0, 10'd1023, 8'h00);
        send_word(1'b0, 10'd1000, 8'h00);
        // Zero gains with a zero clamp: duty stuck at zero
        drain_results();
        apply_gains(16'd0, 16'd0, 16'd0, 7'd0);
        send_word(1'b0, 10'd0, 8'h00);
        send_word(1'b0, 10'd1023, 8'h00);
        // Narrowest nonzero clamp
        drain_results();
        apply_gains(KP_RESET, KI_RESET, KD_RESET, 7'd1);
        send_word(1'b0, 10'd0, 8'h00);
        send_word(1'b0, 10'd500, 8'h00);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: apply_gains(KP_RESET, KI_RESET, KD_RESET, DUTY_RESET);
                1: apply_gains(GAIN_W'($urandom_range(65535)), GAIN_W'($urandom_range(65535)),
                               GAIN_W'($urandom_range(65535)),
                               DUTY_W'($urandom_range(1, 100)));
                2: apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
                3: apply_gains(GAIN_W'($urandom_range(2000)), 16'd0,
                               GAIN_W'($urandom_range(8000)), 7'd0);
                default: apply_gains(GAIN_W'($urandom_range(4000)),
                                     GAIN_W'($urandom_range(300)),
                                     GAIN_W'($urandom_range(8000)),
                                     DUTY_W'($urandom_range(1, 100)));
            endcase
            // One phase runs with no idling on either side
            idle_on = (ph != 5);
            for (int n = 0; n < RANDOM_PHASE_WORDS; n++) begin
                // Stall the receiver long enough to back up the pipe while
                // the sender keeps offering words
                if (ph == 2 && n == 40) hold_left = HOLD_CYCLES;
                // Pause the sender until everything is back
                if (ph == 6 && n == 70) drain_results();
                send_random_word();
            end
        end

        // One-sided runs: small ki keeps the integral visible in the duty
        // while it winds up at either end of the scale
        drain_results();
        idle_on = 1'b0;
        apply_gains(KP_RESET, 16'd1, KD_RESET, 7'd127);
        repeat (8) send_word(1'b1, 10'd0, KEY_UP_LARGE);
        repeat (POS_SAT_WORDS) begin
            adc = ($urandom_range(99) == 0) ? ADC_PORT_W'($urandom_range(1023)) : 10'd0;
            send_word(1'b0, adc, KEY_W'($urandom_range(255)));
        end
        repeat (20) send_word(1'b0, ADC_PORT_W'($urandom_range(1023)), 8'h00);
        // Walk down to the bottom setpoint, then push past it
        repeat (11) send_word(1'b1, 10'd0, KEY_DN_LARGE);
        send_word(1'b1, 10'd0, KEY_DN_SMALL);
        repeat (NEG_SAT_WORDS) begin
            adc = ($urandom_range(99) == 0) ? ADC_PORT_W'($urandom_range(1023)) : 10'd1023;
            send_word(1'b0, adc, KEY_W'($urandom_range(255)));
        end
        repeat (20) send_word(1'b0, ADC_PORT_W'($urandom_range(1023)), 8'h00);
        idle_on = 1'b1;

        // Wind down: wait for the last words and let any stray words arrive before the verdict
        i_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0)
            $display("%0d result words never arrived", sb.pending());
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[pid_temperature_duty_controller_top] OK");
        else
            $display("[pid_temperature_duty_controller_top] ERROR");
        $finish;
    end

endmodule
